@@ design/pre_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pre_pkg
// Shared types and helpers for the polyline ribbon extruder.
// ---------------------------------------------------------------------------
package pre_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load_in;
    logic       store_first;
    logic       start_diff;
    logic       norm_shift;
    logic       sq_step;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       mul_step;
    logic       emit_vtx;
    logic       emit_pix;
    logic [1:0] sel;
  } pre_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pixel_mode;
    logic have_prev;
    logic norm_done;
    logic out_free;
  } pre_status_t;

  // configuration register indexes
  localparam logic REG_THICKNESS = 1'b0;
  localparam logic REG_COLOR     = 1'b1;

  // clamp a 34-bit signed value to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage : pre_pkg
`default_nettype wire

@@ design/pre_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pre_datapath
// Point history, direction normalization, shared square root and divider,
// thickness scaling and the output vertex register.
// ---------------------------------------------------------------------------
module pre_datapath import pre_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [31:0] in_x,
  input  wire logic [31:0] in_y,
  input  wire logic [31:0] in_z,
  input  wire logic        in_start,
  input  wire pre_cmd_t    cmd,
  output pre_status_t      status,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic [31:0]      out_color,
  output logic [15:0]      out_number,
  output logic             out_last
);

  localparam int UW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int PW = UW + 32;
  localparam logic signed [32:0] EPS_Q   = 33'((2 ** FRAC_BITS + 9999) / 10000);
  localparam logic signed [32:0] TENTH_Q = 33'((2 ** FRAC_BITS + 5) / 10);
  localparam logic signed [PW-1:0] ROUND_BIAS = PW'(2 ** (FRAC_BITS + 1) - 1);

  // configuration
  logic signed [31:0] thickness;
  logic [31:0]        color;

  // history and working registers
  logic signed [31:0] cur [3];
  logic signed [31:0] prev [3];
  logic signed [31:0] ecp [3];
  logic signed [31:0] ecm [3];
  logic               have_prev;
  logic [15:0]        seg_count;
  logic [15:0]        emit_count;
  logic [2:0]         dneg;
  logic [32:0]        mag [3];
  logic [61:0]        sum;
  logic [62:0]        sq_n;
  logic [62:0]        sq_r;
  logic [62:0]        sq_bit;
  logic [32:0]        rem;
  logic [QW-1:0]      quo;
  logic signed [UW-1:0] u [3];
  logic signed [31:0] h [3];

  // combinational signals
  logic signed [32:0] d [3];
  logic signed [32:0] dd [3];
  logic [32:0]        mag_new [3];
  logic               tiny;
  logic [32:0]        mx;
  logic [59:0]        sq_prod;
  logic [61:0]        sum_next;
  logic [62:0]        sq_t;
  logic               sq_ge;
  logic [30:0]        len;
  logic               div_ge;
  logic [32:0]        rem_sub;
  logic [QW-1:0]      quo_next;
  logic signed [UW-1:0] q_ext;
  logic signed [PW-1:0] mul_a;
  logic signed [PW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_adj;
  logic signed [PW-1:0] prod_shr;
  logic signed [33:0] so [3];
  logic signed [33:0] du [3];
  logic [31:0]        vtx [3];

  // direction, epsilon fix-up and magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = {prev[i][31], prev[i]} - {cur[i][31], cur[i]};
    end
    tiny = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!(d[i] > -EPS_Q && d[i] < EPS_Q)) tiny = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      dd[i] = (i == 0 && tiny) ? TENTH_Q : d[i];
      mag_new[i] = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
    end
  end

  // largest magnitude for normalization
  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  // sum of squares, square root step and divider step
  always_comb begin
    sq_prod  = mag[cmd.sel][29:0] * mag[cmd.sel][29:0];
    sum_next = sum + 62'(sq_prod);
    sq_t     = sq_r + sq_bit;
    sq_ge    = sq_n >= sq_t;
    len      = sq_r[30:0];
    div_ge   = rem >= {2'b00, len};
    rem_sub  = div_ge ? rem - {2'b00, len} : rem;
    quo_next = {quo[QW-2:0], div_ge};
    q_ext    = {1'b0, quo_next};
  end

  // thickness scaling, truncated toward zero
  always_comb begin
    mul_a    = PW'(u[cmd.sel]);
    mul_b    = PW'(thickness);
    prod     = mul_a * mul_b;
    prod_adj = prod + (prod[PW-1] ? ROUND_BIAS : '0);
    prod_shr = prod_adj >>> (FRAC_BITS + 1);
  end

  // selected ribbon corner
  always_comb begin
    so[0] = -34'(h[2]);
    so[1] = '0;
    so[2] = 34'(h[0]);
    for (int i = 0; i < 3; i++) begin
      du[i] = 34'(h[i]);
    end
    for (int i = 0; i < 3; i++) begin
      case (cmd.sel)
        2'd0: vtx[i] = (seg_count != 16'd0) ? ecp[i] : sat32(34'(prev[i]) + so[i]);
        2'd1: vtx[i] = (seg_count != 16'd0) ? ecm[i] : sat32(34'(prev[i]) - so[i]);
        2'd2: vtx[i] = sat32(34'(cur[i]) + so[i] - du[i]);
        default: vtx[i] = sat32(34'(cur[i]) - so[i] - du[i]);
      endcase
    end
  end

  assign status.pixel_mode = thickness[31];
  assign status.have_prev  = have_prev;
  assign status.norm_done  = (mx[32:30] == 3'd0) && mx[29];
  assign status.out_free   = !out_valid || out_ready;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      thickness  <= 32'(2 ** (FRAC_BITS - 1));
      color      <= 32'hffff_ffff;
      have_prev  <= 1'b0;
      seg_count  <= '0;
      emit_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THICKNESS: thickness <= cfg_data;
          REG_COLOR:     color     <= cfg_data;
        endcase
      end
      if (cmd.load_in && in_start) begin
        have_prev  <= 1'b0;
        seg_count  <= '0;
        emit_count <= '0;
      end
      if (cmd.store_first) have_prev <= 1'b1;
      if (cmd.emit_pix) begin
        have_prev  <= 1'b1;
        seg_count  <= '0;
        emit_count <= emit_count + 16'd1;
      end
      if (cmd.emit_vtx) begin
        emit_count <= emit_count + 16'd1;
        if (cmd.sel == 2'd3 && seg_count != 16'hffff) seg_count <= seg_count + 16'd1;
      end
      if (cmd.emit_vtx || cmd.emit_pix) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur[0] <= in_x;
      cur[1] <= in_y;
      cur[2] <= in_z;
    end
    if (cmd.store_first) begin
      for (int i = 0; i < 3; i++) prev[i] <= cur[i];
    end
    if (cmd.start_diff) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]  <= mag_new[i];
        dneg[i] <= dd[i][32];
      end
      sum <= '0;
    end
    if (cmd.norm_shift) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= (mx[32:30] != 3'd0) ? (mag[i] >> 1) : (mag[i] << 1);
      end
    end
    if (cmd.sq_step) begin
      sum <= sum_next;
      if (cmd.sel == 2'd2) begin
        sq_n   <= 63'(sum_next);
        sq_r   <= '0;
        sq_bit <= 63'(1) << 62;
      end
    end
    if (cmd.sqrt_step) begin
      if (sq_ge) begin
        sq_n <= sq_n - sq_t;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.div_init) begin
      rem <= mag[cmd.sel];
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= {rem_sub[31:0], 1'b0};
      quo <= quo_next;
    end
    if (cmd.div_store) begin
      u[cmd.sel] <= dneg[cmd.sel] ? -q_ext : q_ext;
    end
    if (cmd.mul_step) begin
      h[cmd.sel] <= prod_shr[31:0];
    end
    if (cmd.emit_vtx) begin
      out_x      <= vtx[0];
      out_y      <= vtx[1];
      out_z      <= vtx[2];
      out_color  <= color;
      out_number <= emit_count;
      out_last   <= (cmd.sel == 2'd3);
      if (cmd.sel == 2'd2) begin
        for (int i = 0; i < 3; i++) ecp[i] <= vtx[i];
      end
      if (cmd.sel == 2'd3) begin
        for (int i = 0; i < 3; i++) begin
          ecm[i]  <= vtx[i];
          prev[i] <= cur[i];
        end
      end
    end
    if (cmd.emit_pix) begin
      out_x      <= cur[0];
      out_y      <= cur[1];
      out_z      <= cur[2];
      out_color  <= color;
      out_number <= emit_count;
      out_last   <= 1'b1;
      for (int i = 0; i < 3; i++) prev[i] <= cur[i];
    end
  end

endmodule : pre_datapath
`default_nettype wire

@@ design/pre_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pre_ctrl
// Sequencer for one point: history check, normalization, root, divides,
// scaling and vertex issue.
// ---------------------------------------------------------------------------
module pre_ctrl import pre_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire pre_status_t status,
  output pre_cmd_t         cmd
);

  localparam logic [5:0] DIV_LAST  = 6'(FRAC_BITS + 1);
  localparam logic [5:0] SQRT_LAST = 6'd31;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_NORM  = 9'b000000100,
    S_SQ    = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_PIX   = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] sel, sel_next;
  logic [5:0] step, step_next;

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    sel_next   = sel;
    step_next  = step;
    cmd        = '0;
    cmd.sel    = sel;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.pixel_mode) begin
          state_next = S_PIX;
        end else if (!status.have_prev) begin
          cmd.store_first = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.start_diff = 1'b1;
          state_next     = S_NORM;
        end
      end
      S_NORM: begin
        if (status.norm_done) begin
          sel_next   = 2'd0;
          state_next = S_SQ;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (sel == 2'd2) begin
          step_next  = '0;
          state_next = S_SQRT;
        end else begin
          sel_next = sel + 2'd1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == SQRT_LAST) begin
          step_next  = '0;
          sel_next   = 2'd0;
          state_next = S_DIV;
        end else begin
          step_next = step + 6'd1;
        end
      end
      S_DIV: begin
        if (step == 6'd0) begin
          cmd.div_init = 1'b1;
          step_next    = step + 6'd1;
        end else begin
          cmd.div_step = 1'b1;
          if (step == DIV_LAST) begin
            cmd.div_store = 1'b1;
            step_next     = '0;
            if (sel == 2'd2) begin
              sel_next   = 2'd0;
              state_next = S_MUL;
            end else begin
              sel_next = sel + 2'd1;
            end
          end else begin
            step_next = step + 6'd1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sel == 2'd2) begin
          sel_next   = 2'd0;
          state_next = S_EMIT;
        end else begin
          sel_next = sel + 2'd1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_vtx = 1'b1;
          if (sel == 2'd3) begin
            sel_next   = 2'd0;
            state_next = S_IDLE;
          end else begin
            sel_next = sel + 2'd1;
          end
        end
      end
      S_PIX: begin
        if (status.out_free) begin
          cmd.emit_pix = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      step  <= step_next;
    end
  end

endmodule : pre_ctrl
`default_nettype wire

@@ design/polyline_ribbon_extruder_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// polyline_ribbon_extruder_top
// Turns a stream of polyline points into colored ribbon quad vertices.
// ---------------------------------------------------------------------------
// One point is taken at a time. In ribbon mode a segment point goes through
// the one-bit normalization shifts of the direction, the sum of squares,
// the 32-step square root, the three bit-serial divides, the thickness
// scaling and the issue of four vertices. The first point of a line emits
// nothing; a point in pixel-line mode emits one vertex. Output stalls delay
// a point only while a vertex waits in the output register.
module polyline_ribbon_extruder_top import pre_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data,
  // input points
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,   // point_x, point_y, point_z
  input  wire logic         s_tuser,   // starts_line
  // output vertices
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,   // vertex_x, vertex_y, vertex_z, out_color, vertex_number
  output logic              m_tlast    // last_of_run
);

  pre_cmd_t    cmd;
  pre_status_t status;
  logic [31:0] out_x, out_y, out_z, out_color;
  logic [15:0] out_number;

  pre_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pre_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_x       (s_tdata[31:0]),
    .in_y       (s_tdata[63:32]),
    .in_z       (s_tdata[95:64]),
    .in_start   (s_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_color  (out_color),
    .out_number (out_number),
    .out_last   (m_tlast)
  );

  assign m_tdata = {out_number, out_color, out_z, out_y, out_x};

endmodule : polyline_ribbon_extruder_top
`default_nettype wire

@@ design/pre_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pre_checker
// Port-level checks on the ribbon extruder streams.
// ---------------------------------------------------------------------------
module pre_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [143:0] m_tdata,
  input wire logic         m_tlast
);

  // a stalled vertex holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled vertex changed");

  // one point at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a point is in work");

  // no new point while a quad is still being issued
  a_quad: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("input ready in the middle of a quad");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("vertex valid after reset");

endmodule : pre_checker

bind polyline_ribbon_extruder_top pre_checker u_pre_checker (.*);
`default_nettype wire
